@@ rtl/bst_pkg.sv @@
// Package: shared constants, codes and controller/datapath interface types.
`default_nettype none
package bst_pkg;
    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_W     = 3;
    localparam int PEND_DEPTH = 16;
    localparam int PEND_W     = 4;
    localparam int CNT_W      = 5;
    localparam int ID_W       = 31;
    localparam int OWNER_W    = 32;
    localparam int WORD_W     = 32;
    localparam int PAY_W      = 5 * WORD_W;
    localparam int PEND_RAM_W = ID_W + PAY_W;
    localparam int N_POS      = 4 * NUM_SLOTS;
    localparam int POS_W      = 5;
    localparam int KIND_W     = 2;

    localparam logic [KIND_W-1:0] KIND_DIED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALIVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REVIVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd3;

    localparam logic [OWNER_W-1:0] NO_OWNER = '1;

    typedef struct packed {
        logic              in_acc;
        logic              die;
        logic              pend_rd;
        logic              assign_slot;
        logic              build;
        logic              emit_ev;
        logic              data_rd;
        logic              data_load;
        logic              clear;
        logic [PEND_W-1:0] k;
        logic [POS_W-1:0]  p;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] pend_cnt;
        logic             cur_set;
        logic             is_data;
        logic             out_free;
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/bst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/bst_ctrl.sv @@
// Controller: frame sequencing state machine.
`default_nettype none
module bst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_frame_end,
    output logic               o_stall,
    input  wire bst_pkg::t_sts i_sts,
    output bst_pkg::t_cmd      o_cmd
);
    import bst_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIE     = 3'd1;
    localparam logic [2:0] S_AS_RD   = 3'd2;
    localparam logic [2:0] S_AS_WR   = 3'd3;
    localparam logic [2:0] S_BUILD   = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;
    localparam logic [2:0] S_EMIT_RD = 3'd6;
    localparam logic [2:0] S_CLEAR   = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_k, n_k;
    logic [POS_W-1:0] r_p, n_p;
    logic             adv;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        o_cmd.k = r_k[PEND_W-1:0];
        o_cmd.p = r_p;
        n_state = r_state;
        n_k     = r_k;
        n_p     = r_p;
        adv     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_acc = i_valid;
                if (i_valid && i_frame_end) begin
                    n_state = S_DIE;
                end
            end
            S_DIE: begin
                o_cmd.die = 1'b1;
                n_k       = '0;
                n_state   = S_AS_RD;
            end
            S_AS_RD: begin
                if (r_k == i_sts.pend_cnt) begin
                    n_state = S_BUILD;
                end else begin
                    o_cmd.pend_rd = 1'b1;
                    n_state       = S_AS_WR;
                end
            end
            S_AS_WR: begin
                o_cmd.assign_slot = 1'b1;
                n_k               = r_k + CNT_W'(1);
                n_state           = S_AS_RD;
            end
            S_BUILD: begin
                o_cmd.build = 1'b1;
                n_p         = '0;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.cur_set) begin
                    adv = 1'b1;
                end else if (i_sts.out_free) begin
                    if (i_sts.is_data) begin
                        o_cmd.data_rd = 1'b1;
                        n_state       = S_EMIT_RD;
                    end else begin
                        o_cmd.emit_ev = 1'b1;
                        adv           = 1'b1;
                    end
                end
            end
            S_EMIT_RD: begin
                o_cmd.data_load = 1'b1;
                adv             = 1'b1;
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (adv) begin
            if (r_p == POS_W'(N_POS - 1)) begin
                n_state = S_CLEAR;
            end else begin
                n_p     = r_p + POS_W'(1);
                n_state = S_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_p     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_p     <= n_p;
        end
    end
endmodule
`default_nettype wire

@@ rtl/bst_dp.sv @@
// Datapath: slot table, pending buffer, event flags and output register.
`default_nettype none
module bst_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bst_pkg::t_cmd              i_cmd,
    output bst_pkg::t_sts                   o_sts,
    input  wire logic                       i_has_blob,
    input  wire logic [bst_pkg::ID_W-1:0]   i_blob_id,
    input  wire logic [bst_pkg::PAY_W-1:0]  i_pay,
    input  wire logic                       i_out_stall,
    output logic                            o_valid,
    output logic [bst_pkg::KIND_W-1:0]      o_kind,
    output logic [bst_pkg::SLOT_W-1:0]      o_slot,
    output logic [bst_pkg::ID_W-1:0]        o_out_id,
    output logic [bst_pkg::PAY_W-1:0]       o_pay,
    output logic                            o_last_of_run
);
    import bst_pkg::*;

    logic [OWNER_W-1:0] r_owner   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_matched, r_active;
    logic [NUM_SLOTS-1:0] r_died, r_alive, r_revive;
    logic [CNT_W-1:0]   r_cnt;
    logic [N_POS-1:0]   r_emit;

    logic               hit_any, free_any;
    logic [SLOT_W-1:0]  hit_idx, free_idx;
    logic               blob_in;

    logic               s_we;
    logic [SLOT_W-1:0]  s_waddr, s_raddr;
    logic [PAY_W-1:0]   s_wdata, s_rdata;
    logic               p_we;
    logic [PEND_RAM_W-1:0] p_rdata;

    logic [KIND_W-1:0]  cur_kind;
    logic [SLOT_W-1:0]  cur_slot;
    logic               cur_last;
    logic               out_acc;

    assign blob_in = i_cmd.in_acc && i_has_blob;

    // lowest slot owned by the incoming id, lowest unmatched slot
    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_owner[i] == {1'b0, i_blob_id}) begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!r_matched[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign cur_kind = i_cmd.p[POS_W-1:SLOT_W];
    assign cur_slot = SLOT_W'(NUM_SLOTS - 1) - i_cmd.p[SLOT_W-1:0];
    assign cur_last = (r_emit & ~((N_POS'(2) << i_cmd.p) - N_POS'(1))) == '0;
    assign out_acc  = o_valid && !i_out_stall;

    assign o_sts.pend_cnt = r_cnt;
    assign o_sts.cur_set  = r_emit[i_cmd.p];
    assign o_sts.is_data  = (cur_kind == KIND_DATA);
    assign o_sts.out_free = !o_valid || out_acc;

    assign s_we    = (blob_in && hit_any) || (i_cmd.assign_slot && free_any);
    assign s_waddr = i_cmd.assign_slot ? free_idx : hit_idx;
    assign s_wdata = i_cmd.assign_slot ? p_rdata[PAY_W-1:0] : i_pay;
    assign s_raddr = cur_slot;
    assign p_we    = blob_in && !hit_any && (r_cnt < CNT_W'(PEND_DEPTH));

    bst_ram #(.WIDTH(PAY_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    bst_ram #(.WIDTH(PEND_RAM_W), .DEPTH(PEND_DEPTH)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_cnt[PEND_W-1:0]),
        .i_wdata ({i_blob_id, i_pay}),
        .i_raddr (i_cmd.k),
        .o_rdata (p_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_owner[i] <= NO_OWNER;
            end
            r_matched <= '0;
            r_active  <= '0;
            r_died    <= '0;
            r_alive   <= '0;
            r_revive  <= '0;
            r_cnt     <= '0;
            r_emit    <= '0;
            o_valid   <= 1'b0;
        end else begin
            if (blob_in && hit_any) begin
                if (!r_active[hit_idx]) begin
                    r_revive[hit_idx] <= 1'b1;
                end
                r_matched[hit_idx] <= 1'b1;
                r_active[hit_idx]  <= 1'b1;
            end
            if (p_we) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.die) begin
                r_died   <= r_died | (r_active & ~r_matched);
                r_active <= r_active & r_matched;
            end
            if (i_cmd.assign_slot && free_any) begin
                r_matched[free_idx] <= 1'b1;
                r_active[free_idx]  <= 1'b1;
                r_alive[free_idx]   <= 1'b1;
                r_owner[free_idx]   <= {1'b0, p_rdata[PEND_RAM_W-1:PAY_W]};
            end
            if (i_cmd.build) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    r_emit[NUM_SLOTS - 1 - i]         <= r_died[i];
                    r_emit[2 * NUM_SLOTS - 1 - i]     <= r_alive[i];
                    r_emit[3 * NUM_SLOTS - 1 - i]     <= r_revive[i];
                    r_emit[4 * NUM_SLOTS - 1 - i]     <= r_matched[i];
                end
            end
            if (i_cmd.clear) begin
                r_matched <= '0;
                r_died    <= '0;
                r_alive   <= '0;
                r_revive  <= '0;
                r_cnt     <= '0;
            end
            if (i_cmd.emit_ev || i_cmd.data_load) begin
                o_valid <= 1'b1;
            end else if (out_acc) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ev) begin
            o_kind        <= cur_kind;
            o_slot        <= cur_slot;
            o_out_id      <= '0;
            o_pay         <= '0;
            o_last_of_run <= cur_last;
        end else if (i_cmd.data_load) begin
            o_kind        <= KIND_DATA;
            o_slot        <= cur_slot;
            o_out_id      <= r_owner[cur_slot][ID_W-1:0];
            o_pay         <= s_rdata;
            o_last_of_run <= cur_last;
        end
    end
endmodule
`default_nettype wire

@@ rtl/blob_slot_tracker.sv @@
// Top level: multitouch slot tracker, controller plus datapath.
// Frame pass: a frame-end item runs the die, assign (read and write per pending new blob),
// build, emit (an extra read per blob data result) and clear states, and it waits while
// the output side stalls. One result at most in flight.
// Throughput: one item per cycle between frame ends; input stalls during the pass.
// Reset: synchronous active low; slots own no blob, flags and pending count clear.
`default_nettype none
module blob_slot_tracker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_has_blob,
    input  wire logic [bst_pkg::ID_W-1:0]  i_blob_id,
    input  wire logic [bst_pkg::WORD_W-1:0] i_arg0,
    input  wire logic [bst_pkg::WORD_W-1:0] i_arg1,
    input  wire logic [bst_pkg::WORD_W-1:0] i_arg2,
    input  wire logic [bst_pkg::WORD_W-1:0] i_arg3,
    input  wire logic [bst_pkg::WORD_W-1:0] i_arg4,
    input  wire logic                      i_frame_end,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [bst_pkg::KIND_W-1:0]     o_kind,
    output logic [bst_pkg::SLOT_W-1:0]     o_slot,
    output logic [bst_pkg::ID_W-1:0]       o_out_id,
    output logic [bst_pkg::WORD_W-1:0]     o_out0,
    output logic [bst_pkg::WORD_W-1:0]     o_out1,
    output logic [bst_pkg::WORD_W-1:0]     o_out2,
    output logic [bst_pkg::WORD_W-1:0]     o_out3,
    output logic [bst_pkg::WORD_W-1:0]     o_out4,
    output logic                           o_last_of_run
);
    import bst_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic [PAY_W-1:0] pay_out;

    // sequence input transactions and the frame-end pass
    bst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_frame_end (i_frame_end),
        .o_stall     (o_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // hold slot state and drive the result register
    bst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_has_blob    (i_has_blob),
        .i_blob_id     (i_blob_id),
        .i_pay         ({i_arg4, i_arg3, i_arg2, i_arg1, i_arg0}),
        .i_out_stall   (i_stall),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_slot        (o_slot),
        .o_out_id      (o_out_id),
        .o_pay         (pay_out),
        .o_last_of_run (o_last_of_run)
    );

    assign o_out0 = pay_out[WORD_W-1:0];
    assign o_out1 = pay_out[2*WORD_W-1:WORD_W];
    assign o_out2 = pay_out[3*WORD_W-1:2*WORD_W];
    assign o_out3 = pay_out[4*WORD_W-1:3*WORD_W];
    assign o_out4 = pay_out[5*WORD_W-1:4*WORD_W];
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for blob_slot_tracker: queued driver, monitor and slot-assignment predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import bst_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    // One input transaction as the driver presents it.
    typedef struct {
        logic               has_blob;
        logic [ID_W-1:0]    blob_id;
        logic [WORD_W-1:0]  arg [5];
        logic               frame_end;
    } t_item;

    // One result transaction as the monitor sees it.
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    id;
        logic [WORD_W-1:0]  word [5];
        logic               last;
    } t_event;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_has_blob = 1'b0;
    logic [ID_W-1:0]   i_blob_id = '0;
    logic [WORD_W-1:0] i_arg0 = '0, i_arg1 = '0, i_arg2 = '0, i_arg3 = '0, i_arg4 = '0;
    logic              i_frame_end = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [KIND_W-1:0] o_kind;
    logic [SLOT_W-1:0] o_slot;
    logic [ID_W-1:0]   o_out_id;
    logic [WORD_W-1:0] o_out0, o_out1, o_out2, o_out3, o_out4;
    logic              o_last_of_run;

    blob_slot_tracker u_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: a private copy of the slot table and the pending buffer.
    logic [OWNER_W-1:0] owner_q [NUM_SLOTS];
    logic               matched_q [NUM_SLOTS];
    logic               active_q [NUM_SLOTS];
    logic [WORD_W-1:0]  slot_words_q [NUM_SLOTS][5];
    logic [2:0]         flags_q [NUM_SLOTS];
    t_item              new_blobs_q [$];

    t_item  pending_items [$];
    t_event expected_events [$];
    bit     failed = 1'b0;
    bit     stimulus_done = 1'b0;
    bit     hold_off_req = 1'b0;
    int     idle_cycles = 0;
    logic   in_taken = 1'b0;

    // Known ids, so that random blobs often match an owned slot.
    logic [ID_W-1:0] id_pool [$];

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_slot_table();
        for (int s = 0; s < NUM_SLOTS; s++) begin
            owner_q[s] = NO_OWNER;
            matched_q[s] = 1'b0;
            active_q[s] = 1'b0;
            flags_q[s] = '0;
        end
        new_blobs_q.delete();
    endtask

    task automatic push_event(logic [KIND_W-1:0] kind, int s, logic [ID_W-1:0] id,
                              logic [WORD_W-1:0] w [5]);
        t_event ev;
        ev.kind = kind;
        ev.slot = s[SLOT_W-1:0];
        ev.id = id;
        ev.word = w;
        ev.last = 1'b0;
        expected_events = {expected_events, ev};
    endtask

    // Append one item to the stimulus queue.
    task automatic queue_item(t_item it);
        pending_items = {pending_items, it};
    endtask

    // Track one accepted transaction; on frame end, resolve and queue results.
    task automatic track_blob(t_item it);
        int hit;
        int produced;
        logic [WORD_W-1:0] zero_words [5];
        hit = -1;
        produced = 0;
        zero_words = '{default: '0};
        if (it.has_blob) begin
            for (int s = 0; s < NUM_SLOTS; s++)
                if (hit < 0 && owner_q[s] == {1'b0, it.blob_id}) hit = s;
            if (hit >= 0) begin
                if (!active_q[hit]) flags_q[hit][2] = 1'b1;
                matched_q[hit] = 1'b1;
                active_q[hit] = 1'b1;
                slot_words_q[hit] = it.arg;
            end else if (new_blobs_q.size() < PEND_DEPTH) begin
                new_blobs_q = {new_blobs_q, it};
            end
        end
        if (!it.frame_end) return;
        for (int s = 0; s < NUM_SLOTS; s++)
            if (active_q[s] && !matched_q[s]) begin
                flags_q[s][0] = 1'b1;
                active_q[s] = 1'b0;
            end
        foreach (new_blobs_q[k]) begin
            for (int s = 0; s < NUM_SLOTS; s++)
                if (!matched_q[s]) begin
                    matched_q[s] = 1'b1;
                    active_q[s] = 1'b1;
                    owner_q[s] = {1'b0, new_blobs_q[k].blob_id};
                    slot_words_q[s] = new_blobs_q[k].arg;
                    flags_q[s][1] = 1'b1;
                    break;
                end
        end
        new_blobs_q.delete();
        for (int b = 0; b < 3; b++)
            for (int s = NUM_SLOTS - 1; s >= 0; s--)
                if (flags_q[s][b]) begin
                    push_event(KIND_W'(b), s, '0, zero_words);
                    produced++;
                end
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
            if (matched_q[s]) begin
                push_event(KIND_DATA, s, owner_q[s][ID_W-1:0], slot_words_q[s]);
                produced++;
            end
        if (produced > 0) expected_events[$].last = 1'b1;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            matched_q[s] = 1'b0;
            flags_q[s] = '0;
        end
    endtask

    function automatic t_item make_item(logic has, logic [ID_W-1:0] id, logic fe);
        t_item it;
        it.has_blob = has;
        it.blob_id = id;
        for (int j = 0; j < 5; j++) it.arg[j] = $urandom();
        it.frame_end = fe;
        return it;
    endfunction

    // Pick an id: mostly a known one so slots get matched, sometimes fresh.
    function automatic logic [ID_W-1:0] pick_id();
        logic [ID_W-1:0] id;
        if (id_pool.size() > 0 && $urandom_range(0, 99) < 65)
            return id_pool[$urandom_range(0, id_pool.size() - 1)];
        id = ID_W'($urandom());
        if ($urandom_range(0, 9) == 0) id = '1;
        id_pool = {id_pool, id};
        if (id_pool.size() > 24) void'(id_pool.pop_front());
        return id;
    endfunction

    // Fill the stimulus queue: directed frames first, then random frames.
    initial begin
        t_item it;
        int n_blobs;
        int queued;
        // Bare frame end on an empty table: no results.
        queue_item(make_item(1'b0, '0, 1'b1));
        // New blobs, extreme ids, all-ones and all-zero payloads.
        it = make_item(1'b1, '0, 1'b0);
        it.arg = '{default: '0};
        queue_item(it);
        it = make_item(1'b1, '1, 1'b0);
        it.arg = '{default: '1};
        queue_item(it);
        // Duplicate new id takes its own slot; bare item without frame end.
        queue_item(make_item(1'b1, 31'd5, 1'b0));
        queue_item(make_item(1'b1, 31'd5, 1'b0));
        queue_item(make_item(1'b0, 31'h2AAA_AAAA, 1'b0));
        queue_item(make_item(1'b1, 31'd9, 1'b1));
        // Match id 0 twice (last payload wins); slots of others die.
        queue_item(make_item(1'b1, '0, 1'b0));
        queue_item(make_item(1'b1, '0, 1'b1));
        // Revive a slot that died last frame, with frame end carried on the blob.
        queue_item(make_item(1'b1, '1, 1'b1));
        // Too many new blobs: eighteen fresh ids overflow pending and slots.
        for (int k = 0; k < 18; k++)
            queue_item(make_item(1'b1, ID_W'(32'h100 + k), k == 17));
        for (int j = 0; j < 5; j++) id_pool = {id_pool, ID_W'(32'h100 + j)};
        // Random frames: mostly few blobs with known ids, some noise.
        queued = 0;
        while (queued < 252) begin
            n_blobs = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(0, 6);
            for (int k = 0; k < n_blobs; k++) begin
                it = make_item($urandom_range(0, 9) != 0, pick_id(), 1'b0);
                queue_item(it);
            end
            it = make_item(1'($urandom_range(0, 1)), pick_id(), 1'b1);
            queue_item(it);
            queued += n_blobs + 1;
        end
    end

    // Record whether the input transaction was taken at this rising edge.
    always @(posedge i_clk) begin
        in_taken <= i_valid && !o_stall;
    end

    // Driver: present items at the falling edge, hold while stalled.
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                // start a gap after each taken item
                if (i_valid) send_gap = gap_len();
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    t_item it;
                    it = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_has_blob <= it.has_blob;
                    i_blob_id <= it.blob_id;
                    i_arg0 <= it.arg[0];
                    i_arg1 <= it.arg[1];
                    i_arg2 <= it.arg[2];
                    i_arg3 <= it.arg[3];
                    i_arg4 <= it.arg[4];
                    i_frame_end <= it.frame_end;
                end else begin
                    i_valid <= 1'b0;
                    stimulus_done = 1'b1;
                end
            end
        end
    end

    // Receiver stall: random gaps, plus one long hold-off while the sender keeps offering.
    int stall_left = 0;
    int rx_count = 0;
    bit held_off = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!held_off && rx_count >= 20) begin
                held_off = 1'b1;
                stall_left = 300;
                i_stall <= 1'b1;
            end else begin
                stall_left = gap_len();
                i_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Monitor: feed the predictor with accepted inputs and check accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles <= ((i_valid && !o_stall) || (o_valid && !i_stall)) ? 0
                                                                              : idle_cycles + 1;
            if (i_valid && !o_stall) begin
                t_item it;
                it.has_blob = i_has_blob;
                it.blob_id = i_blob_id;
                it.arg = '{i_arg0, i_arg1, i_arg2, i_arg3, i_arg4};
                it.frame_end = i_frame_end;
                track_blob(it);
            end
            if (o_valid && !i_stall) begin
                t_event got, want;
                got.kind = o_kind;
                got.slot = o_slot;
                got.id = o_out_id;
                got.word = '{o_out0, o_out1, o_out2, o_out3, o_out4};
                got.last = o_last_of_run;
                rx_count++;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result kind %0d slot %0d", $time,
                             got.kind, got.slot);
                    failed = 1'b1;
                end else begin
                    want = expected_events.pop_front();
                    if (got.kind !== want.kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                                 got.kind);
                        failed = 1'b1;
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t: slot expected %0d actual %0d", $time, want.slot,
                                 got.slot);
                        failed = 1'b1;
                    end
                    if (got.id !== want.id) begin
                        $display("%0t: out_id expected %h actual %h", $time, want.id, got.id);
                        failed = 1'b1;
                    end
                    for (int j = 0; j < 5; j++)
                        if (got.word[j] !== want.word[j]) begin
                            $display("%0t: out%0d expected %h actual %h", $time, j,
                                     want.word[j], got.word[j]);
                            failed = 1'b1;
                        end
                    if (got.last !== want.last) begin
                        $display("%0t: last_of_run expected %0d actual %0d", $time,
                                 want.last, got.last);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Reset, then wait for the stimulus to drain and the block to settle.
    initial begin
        clear_slot_table();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (!(stimulus_done && !i_valid && expected_events.size() == 0)) begin
            @(posedge i_clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
        // Let any trailing frame pass finish; stray results are caught by the monitor.
        repeat (200) @(posedge i_clk);
        if (!failed && expected_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
